// File: rtl/core/uvsg_pkg.sv
// Shared types, constants and helper functions of the UV-sphere vertex generator.
package uvsg_pkg;

	localparam int FRAC_BITS     = 14;
	localparam int MAX_DIVISIONS = 1024;
	localparam int CNT_W         = 11;
	localparam int STK_W         = 10;
	localparam int SLC_W         = 11;
	localparam int POS_W         = 16;
	localparam int TEX_W         = 15;

	// pipelined divider: 33 quotient bits, divisor up to 2*MAX_DIVISIONS
	localparam int Q_W     = 33;
	localparam int DVS_W   = 12;
	localparam int DVD_W   = Q_W + DVS_W;
	localparam int NUM_DIV = 4;
	localparam int DIV_AZ  = 0;
	localparam int DIV_POL = 1;
	localparam int DIV_S   = 2;
	localparam int DIV_T   = 3;

	// rotation unit: angles are 32-bit fractions of a turn, datapath in Q30
	localparam int ANG_W        = 32;
	localparam int CW           = 33;
	localparam int SC_W         = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int NUM_ANG      = 2;
	localparam int ANG_AZ       = 0;
	localparam int ANG_POL      = 1;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	// rounding of the products and of the cosine down to FRAC_BITS
	localparam int PROD_W = 2 * SC_W;
	localparam int RSH_XY = 60 - FRAC_BITS;
	localparam int RSH_Z  = 30 - FRAC_BITS;
	localparam int RND_W  = PROD_W - RSH_XY;
	localparam int ZR_W   = SC_W + 1 - RSH_Z;
	localparam logic signed [PROD_W-1:0] RND_XY = PROD_W'(64'sd1 <<< (RSH_XY - 1));
	localparam logic signed [SC_W:0]     RND_Z  = (SC_W + 1)'(33'sd1 <<< (RSH_Z - 1));
	localparam logic signed [POS_W-1:0]  ONE    = POS_W'(1 << FRAC_BITS);

	typedef struct packed {
		logic last;
		logic err;
		logic wrap;
		logic inward;
	} tag_t;

	typedef struct packed {
		tag_t             tag;
		logic [TEX_W-1:0] s;
		logic [TEX_W-1:0] t;
	} vtag_t;

	// zero counts as one, anything above the limit as the limit
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0)
			r = CNT_W'(1);
		else if (c > CNT_W'(MAX_DIVISIONS))
			r = CNT_W'(MAX_DIVISIONS);
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_unit(input logic signed [RND_W-1:0] v);
		logic signed [POS_W-1:0] r;
		r = v[POS_W-1:0];
		if (v > RND_W'(1 << FRAC_BITS))
			r = ONE;
		else if (v < -RND_W'(1 << FRAC_BITS))
			r = -ONE;
		return r;
	endfunction

	// atan(2^-k) in units of 2^-32 turn
	function automatic logic signed [CW-1:0] atan_turn(input int k);
		logic signed [CW-1:0] r;
		unique case (k)
			0:  r = 33'sh020000000;
			1:  r = 33'sh012E4051E;
			2:  r = 33'sh009FB385B;
			3:  r = 33'sh0051111D4;
			4:  r = 33'sh0028B0D43;
			5:  r = 33'sh00145D7E1;
			6:  r = 33'sh000A2F61E;
			7:  r = 33'sh000517C55;
			8:  r = 33'sh00028BE53;
			9:  r = 33'sh000145F2F;
			10: r = 33'sh0000A2F98;
			11: r = 33'sh0000517CC;
			12: r = 33'sh000028BE6;
			13: r = 33'sh0000145F3;
			14: r = 33'sh00000A2FA;
			15: r = 33'sh00000517D;
			16: r = 33'sh0000028BE;
			17: r = 33'sh00000145F;
			18: r = 33'sh000000A30;
			19: r = 33'sh000000518;
			20: r = 33'sh00000028C;
			21: r = 33'sh000000146;
			22: r = 33'sh0000000A3;
			23: r = 33'sh000000051;
			24: r = 33'sh000000029;
			25: r = 33'sh000000014;
			26: r = 33'sh00000000A;
			27: r = 33'sh000000005;
			28: r = 33'sh000000003;
			29: r = 33'sh000000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/uvsg_issue.sv
// Input holding register that splits each grid point into two vertex jobs.
module uvsg_issue import uvsg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [STK_W-1:0] stack_index,
	input  logic [SLC_W-1:0] slice_index,
	input  logic [CNT_W-1:0] slice_count,
	input  logic [CNT_W-1:0] stack_count,
	input  logic             inside_view,
	input  logic             adv,
	output logic             job_v_s1,
	output tag_t             tag_s1,
	output logic [DVD_W-1:0] dvd_s1 [NUM_DIV],
	output logic [DVS_W-1:0] dvs_s1 [NUM_DIV]
);

	logic             hold_v_q;
	logic             phase_q;
	logic [STK_W-1:0] si_q;
	logic [SLC_W-1:0] sj_q;

	logic             issue_fire;
	logic             last_fire;
	logic             accept;
	logic [CNT_W-1:0] ns;
	logic [CNT_W-1:0] nt;
	logic [CNT_W-1:0] ring;
	logic [CNT_W-1:0] tnum;
	tag_t             tag_d;
	logic [DVD_W-1:0] dvd_d [NUM_DIV];
	logic [DVS_W-1:0] dvs_d [NUM_DIV];

	assign issue_fire = adv && hold_v_q;
	assign last_fire  = issue_fire && phase_q;
	assign in_stall   = hold_v_q && !last_fire;
	assign accept     = in_valid && !in_stall;

	always_comb begin
		ns   = eff_count(slice_count);
		nt   = eff_count(stack_count);
		ring = {1'b0, si_q} + {{(CNT_W-1){1'b0}}, phase_q};
		tnum = inside_view ? ring : nt - ring;

		tag_d.last   = phase_q;
		tag_d.err    = ({1'b0, si_q} >= nt) || (sj_q > ns);
		tag_d.wrap   = (sj_q == ns);
		tag_d.inward = inside_view;

		dvd_d[DIV_AZ]  = {{(DVD_W-SLC_W-ANG_W){1'b0}}, sj_q, {ANG_W{1'b0}}}
			+ {{(DVD_W-CNT_W+1){1'b0}}, ns[CNT_W-1:1]};
		dvd_d[DIV_POL] = {{(DVD_W-CNT_W-ANG_W){1'b0}}, ring, {ANG_W{1'b0}}}
			+ {{(DVD_W-CNT_W){1'b0}}, nt};
		dvd_d[DIV_S]   = {{(DVD_W-SLC_W-FRAC_BITS){1'b0}}, sj_q, {FRAC_BITS{1'b0}}}
			+ {{(DVD_W-CNT_W+1){1'b0}}, ns[CNT_W-1:1]};
		dvd_d[DIV_T]   = {{(DVD_W-CNT_W-FRAC_BITS){1'b0}}, tnum, {FRAC_BITS{1'b0}}}
			+ {{(DVD_W-CNT_W+1){1'b0}}, nt[CNT_W-1:1]};

		dvs_d[DIV_AZ]  = {1'b0, ns};
		dvs_d[DIV_POL] = {nt, 1'b0};
		dvs_d[DIV_S]   = {1'b0, ns};
		dvs_d[DIV_T]   = {1'b0, nt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			phase_q  <= 1'b0;
		end else if (accept) begin
			hold_v_q <= 1'b1;
			phase_q  <= 1'b0;
		end else if (last_fire) begin
			hold_v_q <= 1'b0;
		end else if (issue_fire) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			si_q <= stack_index;
			sj_q <= slice_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			job_v_s1 <= 1'b0;
		else if (adv)
			job_v_s1 <= hold_v_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_d;
			dvd_s1 <= dvd_d;
			dvs_s1 <= dvs_d;
		end
	end

endmodule

// File: rtl/core/uvsg_div.sv
// Four-lane restoring divider, one quotient bit per pipeline stage.
module uvsg_div import uvsg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_v,
	input  tag_t             in_tag,
	input  logic [DVD_W-1:0] dvd [NUM_DIV],
	input  logic [DVS_W-1:0] dvs [NUM_DIV],
	output logic             out_v,
	output tag_t             out_tag,
	output logic [Q_W-1:0]   quo [NUM_DIV]
);

	logic             vld_s [Q_W];
	tag_t             tag_s [Q_W];
	logic [DVS_W-1:0] rem_s [Q_W][NUM_DIV];
	logic [DVS_W-1:0] dvs_s [Q_W][NUM_DIV];
	logic [Q_W-1:0]   dlo_s [Q_W][NUM_DIV];
	logic [Q_W-1:0]   quo_s [Q_W][NUM_DIV];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic             src_v;
		tag_t             src_tag;
		logic [DVS_W-1:0] src_rem [NUM_DIV];
		logic [DVS_W-1:0] src_dvs [NUM_DIV];
		logic [Q_W-1:0]   src_dlo [NUM_DIV];
		logic [Q_W-1:0]   src_quo [NUM_DIV];
		logic [DVS_W-1:0] nxt_rem [NUM_DIV];
		logic [Q_W-1:0]   nxt_quo [NUM_DIV];

		if (i == 0) begin : g_first
			always_comb begin
				src_v   = in_v;
				src_tag = in_tag;
				for (int l = 0; l < NUM_DIV; l++) begin
					src_rem[l] = dvd[l][DVD_W-1:Q_W];
					src_dvs[l] = dvs[l];
					src_dlo[l] = dvd[l][Q_W-1:0];
					src_quo[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				src_v   = vld_s[i-1];
				src_tag = tag_s[i-1];
				for (int l = 0; l < NUM_DIV; l++) begin
					src_rem[l] = rem_s[i-1][l];
					src_dvs[l] = dvs_s[i-1][l];
					src_dlo[l] = dlo_s[i-1][l];
					src_quo[l] = quo_s[i-1][l];
				end
			end
		end

		// shift in the next dividend bit, subtract when it fits
		always_comb begin
			for (int l = 0; l < NUM_DIV; l++) begin
				logic [DVS_W+1:0] diff;
				logic             ge;
				diff = {1'b0, src_rem[l], src_dlo[l][Q_W-1-i]} - {2'b00, src_dvs[l]};
				ge   = !diff[DVS_W+1];
				nxt_rem[l] = ge ? diff[DVS_W-1:0]
					: {src_rem[l][DVS_W-2:0], src_dlo[l][Q_W-1-i]};
				nxt_quo[l] = src_quo[l];
				nxt_quo[l][Q_W-1-i] = ge;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else if (adv)
				vld_s[i] <= src_v;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s[i] <= src_tag;
				rem_s[i] <= nxt_rem;
				dvs_s[i] <= src_dvs;
				dlo_s[i] <= src_dlo;
				quo_s[i] <= nxt_quo;
			end
		end
	end

	assign out_v   = vld_s[Q_W-1];
	assign out_tag = tag_s[Q_W-1];
	assign quo     = quo_s[Q_W-1];

endmodule

// File: rtl/core/uvsg_cordic.sv
// Two-lane pipelined rotation-mode CORDIC with quadrant fold: sine and cosine in Q30.
module uvsg_cordic import uvsg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_v,
	input  vtag_t                  in_tag,
	input  logic [ANG_W-1:0]       ang [NUM_ANG],
	output logic                   out_v,
	output vtag_t                  out_tag,
	output logic signed [SC_W-1:0] co [NUM_ANG],
	output logic signed [SC_W-1:0] sn [NUM_ANG]
);

	logic                 vld_s [CORDIC_STEPS];
	vtag_t                tag_s [CORDIC_STEPS];
	logic signed [CW-1:0] x_s   [CORDIC_STEPS][NUM_ANG];
	logic signed [CW-1:0] y_s   [CORDIC_STEPS][NUM_ANG];
	logic signed [CW-1:0] z_s   [CORDIC_STEPS][NUM_ANG];
	logic [1:0]           qd_s  [CORDIC_STEPS][NUM_ANG];

	logic                 fold_v_s;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic                 src_v;
		vtag_t                src_tag;
		logic signed [CW-1:0] src_x [NUM_ANG];
		logic signed [CW-1:0] src_y [NUM_ANG];
		logic signed [CW-1:0] src_z [NUM_ANG];
		logic [1:0]           src_q [NUM_ANG];
		logic signed [CW-1:0] nx [NUM_ANG];
		logic signed [CW-1:0] ny [NUM_ANG];
		logic signed [CW-1:0] nz [NUM_ANG];

		if (k == 0) begin : g_first
			always_comb begin
				src_v   = in_v;
				src_tag = in_tag;
				for (int l = 0; l < NUM_ANG; l++) begin
					src_x[l] = CORDIC_GAIN;
					src_y[l] = '0;
					src_z[l] = {{(CW-ANG_W+2){1'b0}}, ang[l][ANG_W-3:0]};
					src_q[l] = ang[l][ANG_W-1:ANG_W-2];
				end
			end
		end else begin : g_next
			always_comb begin
				src_v   = vld_s[k-1];
				src_tag = tag_s[k-1];
				for (int l = 0; l < NUM_ANG; l++) begin
					src_x[l] = x_s[k-1][l];
					src_y[l] = y_s[k-1][l];
					src_z[l] = z_s[k-1][l];
					src_q[l] = qd_s[k-1][l];
				end
			end
		end

		// rotate toward zero residual angle
		always_comb begin
			for (int l = 0; l < NUM_ANG; l++) begin
				if (!src_z[l][CW-1]) begin
					nx[l] = src_x[l] - (src_y[l] >>> k);
					ny[l] = src_y[l] + (src_x[l] >>> k);
					nz[l] = src_z[l] - atan_turn(k);
				end else begin
					nx[l] = src_x[l] + (src_y[l] >>> k);
					ny[l] = src_y[l] - (src_x[l] >>> k);
					nz[l] = src_z[l] + atan_turn(k);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (adv)
				vld_s[k] <= src_v;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s[k] <= src_tag;
				x_s[k]   <= nx;
				y_s[k]   <= ny;
				z_s[k]   <= nz;
				qd_s[k]  <= src_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fold_v_s <= 1'b0;
		else if (adv)
			fold_v_s <= vld_s[CORDIC_STEPS-1];
	end

	// fold the first-quadrant result into the quadrant of the angle
	always_ff @(posedge clk) begin
		if (adv) begin
			out_tag <= tag_s[CORDIC_STEPS-1];
			for (int l = 0; l < NUM_ANG; l++) begin
				logic signed [CW-1:0] fx;
				logic signed [CW-1:0] fy;
				fx = x_s[CORDIC_STEPS-1][l];
				fy = y_s[CORDIC_STEPS-1][l];
				unique case (qd_s[CORDIC_STEPS-1][l])
					2'd0: begin
						co[l] <= fx[SC_W-1:0];
						sn[l] <= fy[SC_W-1:0];
					end
					2'd1: begin
						co[l] <= SC_W'(-fy);
						sn[l] <= fx[SC_W-1:0];
					end
					2'd2: begin
						co[l] <= SC_W'(-fx);
						sn[l] <= SC_W'(-fy);
					end
					default: begin
						co[l] <= fy[SC_W-1:0];
						sn[l] <= SC_W'(-fx);
					end
				endcase
			end
		end
	end

	assign out_v = fold_v_s;

endmodule

// File: rtl/core/uvsg_vertex.sv
// Position products, rounding and clamping, and the registered vertex outputs.
module uvsg_vertex import uvsg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_v,
	input  vtag_t                   in_tag,
	input  logic signed [SC_W-1:0]  ca,
	input  logic signed [SC_W-1:0]  sa,
	input  logic signed [SC_W-1:0]  cp,
	input  logic signed [SC_W-1:0]  sp,
	output logic                    out_v,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic signed [POS_W-1:0] norm_x,
	output logic signed [POS_W-1:0] norm_y,
	output logic signed [POS_W-1:0] norm_z,
	output logic [TEX_W-1:0]        tex_s,
	output logic [TEX_W-1:0]        tex_t,
	output logic                    last_of_pair,
	output logic                    index_error
);

	logic                      v_s1;
	vtag_t                     tag_s1;
	logic signed [PROD_W-1:0]  px_s1;
	logic signed [PROD_W-1:0]  py_s1;
	logic signed [SC_W-1:0]    cp_s1;

	logic                      v_s2;
	vtag_t                     tag_s2;
	logic signed [POS_W-1:0]   px_s2;
	logic signed [POS_W-1:0]   py_s2;
	logic signed [POS_W-1:0]   pz_s2;

	logic                      v_s3;

	logic signed [PROD_W-1:0]  sum_x;
	logic signed [PROD_W-1:0]  sum_y;
	logic signed [SC_W:0]      sum_z;
	logic signed [POS_W-1:0]   pz_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= in_tag;
			px_s1  <= sa * sp;
			py_s1  <= ca * sp;
			cp_s1  <= cp;
		end
	end

	// x is the negated product, so round 2^45 - p instead of p
	always_comb begin
		sum_x = RND_XY - px_s1;
		sum_y = py_s1 + RND_XY;
		sum_z = {cp_s1[SC_W-1], cp_s1} + RND_Z;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			px_s2  <= clamp_unit(sum_x[PROD_W-1:RSH_XY]);
			py_s2  <= clamp_unit(sum_y[PROD_W-1:RSH_XY]);
			pz_s2  <= clamp_unit({{(RND_W-ZR_W){sum_z[SC_W]}}, sum_z[SC_W:RSH_Z]});
		end
	end

	assign pz_sel = tag_s2.tag.inward ? -pz_s2 : pz_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			last_of_pair <= tag_s2.tag.last;
			index_error  <= tag_s2.tag.err;
			if (tag_s2.tag.err) begin
				pos_x  <= '0;
				pos_y  <= '0;
				pos_z  <= '0;
				norm_x <= '0;
				norm_y <= '0;
				norm_z <= '0;
				tex_s  <= '0;
				tex_t  <= '0;
			end else begin
				pos_x  <= px_s2;
				pos_y  <= py_s2;
				pos_z  <= pz_sel;
				norm_x <= tag_s2.tag.inward ? -ONE : px_s2;
				norm_y <= tag_s2.tag.inward ? -ONE : py_s2;
				norm_z <= tag_s2.tag.inward ? -ONE : pz_sel;
				tex_s  <= tag_s2.s;
				tex_t  <= tag_s2.t;
			end
		end
	end

	assign out_v = v_s3;

endmodule

// File: rtl/core/uv_sphere_vertex_generator_unit.sv
// Each item yields two vertices over the single output port, one per cycle while
// out_stall is low, through a 33-stage divider, 31-stage CORDIC and 3-stage tail; a new
// item is accepted as the previous one issues its second vertex.
// The whole pipeline holds while the output vertex waits under stall.
// Reset (arst_n low, asynchronous): pipeline empty, slice_count 32, stack_count 16,
// inside_view 0.
module uv_sphere_vertex_generator_unit import uvsg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [STK_W-1:0]        stack_index,
	input  logic [SLC_W-1:0]        slice_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic signed [POS_W-1:0] norm_x,
	output logic signed [POS_W-1:0] norm_y,
	output logic signed [POS_W-1:0] norm_z,
	output logic [TEX_W-1:0]        tex_s,
	output logic [TEX_W-1:0]        tex_t,
	output logic                    last_of_pair,
	output logic                    index_error
);

	localparam logic [1:0] REG_SLICE  = 2'd0;
	localparam logic [1:0] REG_STACK  = 2'd1;
	localparam logic [1:0] REG_INSIDE = 2'd2;

	logic [CNT_W-1:0] slice_count_q;
	logic [CNT_W-1:0] stack_count_q;
	logic             inside_view_q;
	logic             cfg_wr;

	logic             adv;
	logic             job_v;
	tag_t             job_tag;
	logic [DVD_W-1:0] job_dvd [NUM_DIV];
	logic [DVS_W-1:0] job_dvs [NUM_DIV];

	logic             div_v;
	tag_t             div_tag;
	logic [Q_W-1:0]   div_quo [NUM_DIV];

	vtag_t            rot_tag_in;
	logic [ANG_W-1:0] rot_ang [NUM_ANG];
	logic             rot_v;
	vtag_t            rot_tag;
	logic signed [SC_W-1:0] rot_co [NUM_ANG];
	logic signed [SC_W-1:0] rot_sn [NUM_ANG];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_count_q <= CNT_W'(32);
			stack_count_q <= CNT_W'(16);
			inside_view_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SLICE:  slice_count_q <= pwdata[CNT_W-1:0];
				REG_STACK:  stack_count_q <= pwdata[CNT_W-1:0];
				REG_INSIDE: inside_view_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SLICE:  prdata = {{(32-CNT_W){1'b0}}, slice_count_q};
			REG_STACK:  prdata = {{(32-CNT_W){1'b0}}, stack_count_q};
			REG_INSIDE: prdata = {31'd0, inside_view_q};
			default:    prdata = '0;
		endcase
	end

	// hold every stage while the output vertex is stalled
	assign adv = !(out_valid && out_stall);

	uvsg_issue u_issue (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stack_index (stack_index),
		.slice_index (slice_index),
		.slice_count (slice_count_q),
		.stack_count (stack_count_q),
		.inside_view (inside_view_q),
		.adv         (adv),
		.job_v_s1    (job_v),
		.tag_s1      (job_tag),
		.dvd_s1      (job_dvd),
		.dvs_s1      (job_dvs)
	);

	uvsg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (job_v),
		.in_tag  (job_tag),
		.dvd     (job_dvd),
		.dvs     (job_dvs),
		.out_v   (div_v),
		.out_tag (div_tag),
		.quo     (div_quo)
	);

	// the last slice wraps to azimuth zero
	always_comb begin
		rot_ang[ANG_AZ]  = div_tag.wrap ? '0 : div_quo[DIV_AZ][ANG_W-1:0];
		rot_ang[ANG_POL] = div_quo[DIV_POL][ANG_W-1:0];
		rot_tag_in.tag   = div_tag;
		rot_tag_in.s     = div_quo[DIV_S][TEX_W-1:0];
		rot_tag_in.t     = div_quo[DIV_T][TEX_W-1:0];
	end

	uvsg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (div_v),
		.in_tag  (rot_tag_in),
		.ang     (rot_ang),
		.out_v   (rot_v),
		.out_tag (rot_tag),
		.co      (rot_co),
		.sn      (rot_sn)
	);

	uvsg_vertex u_vertex (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_v         (rot_v),
		.in_tag       (rot_tag),
		.ca           (rot_co[ANG_AZ]),
		.sa           (rot_sn[ANG_AZ]),
		.cp           (rot_co[ANG_POL]),
		.sp           (rot_sn[ANG_POL]),
		.out_v        (out_valid),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.tex_s        (tex_s),
		.tex_t        (tex_t),
		.last_of_pair (last_of_pair),
		.index_error  (index_error)
	);

	a_no_back_to_back_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item accepted while the previous one still issues its first vertex");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && index_error) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0
			&& norm_x == '0 && tex_s == '0 && tex_t == '0))
		else $error("vertex with index error carries nonzero fields");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_x >= -ONE && pos_x <= ONE && pos_y >= -ONE && pos_y <= ONE
			&& pos_z >= -ONE && pos_z <= ONE))
		else $error("position outside the unit range");

	a_inside_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !index_error && inside_view_q) |-> (norm_x == -ONE && norm_z == -ONE))
		else $error("inside-view normal is not -1.0");

endmodule
